// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Uses the clk and rst signals visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define GLZ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define GLZ_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define GLZ_ASSERT(label, prop, msg)
`define GLZ_NEVER(label, expr, msg)
`endif
`endif

// ===== hdl/glz_pkg.sv =====
// Shared types, constants and helpers for the GIF LZW decoder.
// No dependencies.
package glz_pkg;

  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int TBL_AW            = 12;     // tables and stack are 4096 deep
  localparam int TBL_DEPTH         = 4096;
  localparam int CODE_W            = 12;
  localparam logic [3:0] MIN_SIZE_RST = 4'd8;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       pixel_valid;
    logic       accepted;
    logic       need_byte;
    logic       done_res;
  } out_t;

  // min code size clamped to 2..9
  function automatic logic [3:0] eff_size(input logic [3:0] s);
    logic [3:0] r;
    r = s;
    if (s < 4'd2) r = 4'd2;
    if (s > 4'd9) r = 4'd9;
    return r;
  endfunction

endpackage

// ===== hdl/glz_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module glz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

// ===== hdl/glz_ctrl.sv =====
// Decoder control: byte framing, bit buffer, code FSM, string tables, stack.
// Depends on glz_pkg, glz_ram and assert_macros.svh.
`include "assert_macros.svh"
module glz_ctrl import glz_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data,
  input  logic       res_ready,
  output logic       res_valid,
  output out_t       res
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_CHAIN  = 2'd2;
  localparam logic [1:0] S_POP    = 2'd3;

  localparam logic [12:0] LIMIT   = 13'(1 << MAX_CODE_BITS);
  localparam logic [3:0]  MAX_CW  = 4'(MAX_CODE_BITS);

  logic [1:0]        state, state_next;
  logic [3:0]        min_size, min_size_next;
  logic [12:0]       stack_count, stack_count_next;
  logic [23:0]       bit_buffer, bit_buffer_next;
  logic [4:0]        bit_count, bit_count_next;
  logic [3:0]        code_width, code_width_next;
  logic [12:0]       next_free, next_free_next;
  logic [CODE_W-1:0] prev_code, prev_code_next;
  logic [7:0]        first_char, first_char_next;
  logic [7:0]        block_rem, block_rem_next;
  logic              expect_root, expect_root_next;
  logic              finished, finished_next;
  logic [CODE_W-1:0] in_code, in_code_next;

  // memory ports
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_ra;
  logic [CODE_W-1:0] prefix_rd;
  logic [7:0]        suffix_rd;
  logic              stk_we;
  logic [TBL_AW-1:0] stk_wa, stk_ra;
  logic [7:0]        stk_wd, stk_rd;

  // code extraction
  logic [3:0]        eff;
  logic [12:0]       clr_code, base_free, cw_mask;
  logic [CODE_W-1:0] raw_code, clamped, start_code, root_code;
  logic              have_bits, kwk, chain_more;

  // shared finish step
  logic              do_fin;
  logic [CODE_W-1:0] fin_code, fin_in_code;
  logic [12:0]       nf_new;
  logic [3:0]        cfg_eff;

  glz_ram #(.WIDTH(CODE_W), .DEPTH(TBL_DEPTH)) u_prefix (
    .clk(clk), .we(tbl_we), .wa(next_free[TBL_AW-1:0]), .wd(prev_code),
    .ra(tbl_ra), .rd(prefix_rd)
  );

  glz_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_suffix (
    .clk(clk), .we(tbl_we), .wa(next_free[TBL_AW-1:0]), .wd(fin_code[7:0]),
    .ra(tbl_ra), .rd(suffix_rd)
  );

  glz_ram #(.WIDTH(8), .DEPTH(TBL_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .wa(stk_wa), .wd(stk_wd), .ra(stk_ra), .rd(stk_rd)
  );

  // code field of the bit buffer
  always_comb begin
    eff        = eff_size(min_size);
    cfg_eff    = eff_size(cfg_data);
    clr_code   = 13'd1 << eff;
    base_free  = clr_code + 13'd2;
    cw_mask    = (13'd1 << code_width) - 13'd1;
    raw_code   = bit_buffer[CODE_W-1:0] & cw_mask[CODE_W-1:0];
    have_bits  = bit_count >= {1'b0, code_width};
    clamped    = ({1'b0, raw_code} > next_free) ? next_free[CODE_W-1:0] : raw_code;
    kwk        = ({1'b0, clamped} == next_free);
    start_code = kwk ? prev_code : clamped;
    root_code  = raw_code & (clr_code[CODE_W-1:0] - 12'd1);
    chain_more = ({1'b0, prefix_rd} >= base_free);
    fin_code    = (state == S_CHAIN) ? prefix_rd : start_code;
    fin_in_code = (state == S_CHAIN) ? in_code : clamped;
    tbl_ra      = (state == S_CHAIN) ? prefix_rd : start_code;
    nf_new      = (next_free < LIMIT) ? next_free + 13'd1 : next_free;
  end

  assign in_ready  = (state == S_IDLE) && res_ready;
  assign cfg_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next       = state;
    min_size_next    = min_size;
    stack_count_next = stack_count;
    bit_buffer_next  = bit_buffer;
    bit_count_next   = bit_count;
    code_width_next  = code_width;
    next_free_next   = next_free;
    prev_code_next   = prev_code;
    first_char_next  = first_char;
    block_rem_next   = block_rem;
    expect_root_next = expect_root;
    finished_next    = finished;
    in_code_next     = in_code;
    res_valid        = 1'b0;
    res              = '0;
    tbl_we           = 1'b0;
    stk_we           = 1'b0;
    stk_wa           = stack_count[TBL_AW-1:0];
    stk_wd           = first_char;
    stk_ra           = 12'(stack_count - 13'd1);
    do_fin           = 1'b0;

    case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          min_size_next    = cfg_data;
          code_width_next  = cfg_eff + 4'd1;
          next_free_next   = (13'd1 << cfg_eff) + 13'd2;
          expect_root_next = 1'b0;
        end
        if (in_valid && in_ready) begin
          if (in_data.cmd == CMD_PUSH) begin
            res_valid = 1'b1;
            if (!finished) begin
              if (block_rem == 8'd0) begin
                if (in_data.in_byte == 8'd0) finished_next = 1'b1;
                else block_rem_next = in_data.in_byte;
                res.accepted = 1'b1;
              end else if (bit_count <= 5'd16) begin
                bit_buffer_next = bit_buffer | ({16'd0, in_data.in_byte} << bit_count);
                bit_count_next  = bit_count + 5'd8;
                block_rem_next  = block_rem - 8'd1;
                res.accepted    = 1'b1;
              end
            end
          end else if (stack_count != 13'd0) begin
            stack_count_next = stack_count - 13'd1;
            state_next       = S_POP;
          end else begin
            state_next = S_DECODE;
          end
        end
      end

      S_POP: begin
        res_valid       = 1'b1;
        res.pixel       = stk_rd;
        res.pixel_valid = 1'b1;
        state_next      = S_IDLE;
      end

      S_DECODE: begin
        if (!have_bits) begin
          res_valid     = 1'b1;
          res.need_byte = !finished;
          res.done_res  = finished;
          state_next    = S_IDLE;
        end else begin
          bit_buffer_next = bit_buffer >> code_width;
          bit_count_next  = bit_count - {1'b0, code_width};
          if ({1'b0, raw_code} == clr_code) begin
            // clear code: restart table, stay to read the next code
            code_width_next  = eff + 4'd1;
            next_free_next   = base_free;
            expect_root_next = 1'b1;
          end else if ({1'b0, raw_code} == clr_code + 13'd1) begin
            finished_next    = 1'b1;
            bit_buffer_next  = '0;
            bit_count_next   = '0;
            expect_root_next = 1'b0;
            res_valid        = 1'b1;
            res.done_res     = 1'b1;
            state_next       = S_IDLE;
          end else if (expect_root) begin
            expect_root_next = 1'b0;
            prev_code_next   = root_code;
            first_char_next  = root_code[7:0];
            res_valid        = 1'b1;
            res.pixel        = root_code[7:0];
            res.pixel_valid  = 1'b1;
            state_next       = S_IDLE;
          end else begin
            // KwKwK: stack the old first char, walk from previous code
            if (kwk) begin
              stk_we           = 1'b1;
              stack_count_next = stack_count + 13'd1;
            end
            in_code_next = clamped;
            if ({1'b0, start_code} >= base_free) state_next = S_CHAIN;
            else do_fin = 1'b1;
          end
        end
      end

      S_CHAIN: begin
        // suffix of the current link onto the stack
        stk_we           = 1'b1;
        stk_wd           = suffix_rd;
        stack_count_next = stack_count + 13'd1;
        if (!chain_more) do_fin = 1'b1;
      end

      default: state_next = S_IDLE;
    endcase

    // end of a string: root char is the pixel, table grows by one entry unless full
    if (do_fin) begin
      first_char_next = fin_code[7:0];
      tbl_we          = (next_free < LIMIT);
      next_free_next  = nf_new;
      prev_code_next  = fin_in_code;
      if (code_width < MAX_CW && {4'd0, nf_new} >= (17'd1 << code_width))
        code_width_next = code_width + 4'd1;
      res_valid       = 1'b1;
      res.pixel       = fin_code[7:0];
      res.pixel_valid = 1'b1;
      state_next      = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      min_size    <= MIN_SIZE_RST;
      stack_count <= '0;
      bit_buffer  <= '0;
      bit_count   <= '0;
      code_width  <= eff_size(MIN_SIZE_RST) + 4'd1;
      next_free   <= (13'd1 << eff_size(MIN_SIZE_RST)) + 13'd2;
      prev_code   <= '0;
      first_char  <= '0;
      block_rem   <= '0;
      expect_root <= 1'b0;
      finished    <= 1'b0;
    end else begin
      state       <= state_next;
      min_size    <= min_size_next;
      stack_count <= stack_count_next;
      bit_buffer  <= bit_buffer_next;
      bit_count   <= bit_count_next;
      code_width  <= code_width_next;
      next_free   <= next_free_next;
      prev_code   <= prev_code_next;
      first_char  <= first_char_next;
      block_rem   <= block_rem_next;
      expect_root <= expect_root_next;
      finished    <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    in_code <= in_code_next;
  end

  `GLZ_ASSERT(a_pull_pops, (in_valid && in_ready && in_data.cmd == CMD_PULL && stack_count != 13'd0) |=> (state == S_POP), "pull with stacked pixels must pop")
  `GLZ_NEVER(a_stack_ovf, stack_count > 13'(TBL_DEPTH), "pixel stack overflow")
  `GLZ_NEVER(a_cw_range, code_width > 4'd12, "code width out of range")
  `GLZ_NEVER(a_bits_range, bit_count > 5'd24, "bit buffer count out of range")

endmodule

// ===== hdl/gif_lzw_decoder.sv =====
// GIF LZW decoder top level: control core plus output result register.
// Depends on glz_pkg, glz_ctrl and assert_macros.svh.
//
// Usage: in_data carries cmd and in_byte. cmd 0 pushes one stream byte
// (sub-block length bytes included, a zero length ends the data); cmd 1
// pulls the next pixel index. Every input transaction yields exactly one
// result transaction on out_data (pixel, pixel_valid, accepted, need_byte,
// done_res). cfg_data writes the minimum code size while the block is idle.
// Timing: a push answers at the accepting edge (result visible next cycle).
// A pull that pops a stacked pixel answers from S_POP after one stack memory read.
// A pull that decodes a code reads codes in S_DECODE, staying there for each
// clear code, then walks the prefix links in S_CHAIN, one prefix table read a
// cycle, until it answers.
// One item is in flight at a time; in_ready is low while a pull decodes or pops,
// or while an unread result sits in the output register and out_ready is low.
// Reset (rst, synchronous) clears control state and sets the minimum code
// size to 8; table and stack memories are not cleared and need no clearing pass.
`include "assert_macros.svh"
module gif_lzw_decoder import glz_pkg::*; #(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  logic res_valid, res_ready;
  out_t res;

  glz_ctrl #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .res_ready(res_ready), .res_valid(res_valid), .res(res)
  );

  // output register is free when empty or drained this cycle
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

  `GLZ_ASSERT(a_no_overwrite, res_valid |-> res_ready, "result overwrites a pending transaction")
  `GLZ_ASSERT(a_one_in_flight, (in_valid && in_ready && in_data.cmd == CMD_PULL) |=> !in_ready, "second item accepted during a pull")
  `GLZ_ASSERT(a_push_answers, (in_valid && in_ready && in_data.cmd == CMD_PUSH) |=> out_valid, "push transaction without result")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for gif_lzw_decoder: directed rows, generated LZW code streams, then the last rows.
// A behavioral decoder model predicts each result that a row does not fix; idle gaps and output stalls are random.
// Depends on glz_pkg (hdl/glz_pkg.sv) and the gif_lzw_decoder RTL.
`timescale 1ns / 100ps

module tb;
  import glz_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_t       out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [3:0] cfg_data = 4'd0;

  gif_lzw_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------
  // Decoder model state
  // ---------------------------------------------------------------
  logic [3:0]  m_size;
  bit [11:0]   m_prefix [TBL_DEPTH];
  bit [7:0]    m_suffix [TBL_DEPTH];
  bit [7:0]    m_stack [TBL_DEPTH];
  int unsigned m_sp, m_buf, m_bits, m_width, m_free, m_prev, m_first, m_blk;
  bit          m_root, m_fin;

  out_t pixel_q [$];   // results still owed by the decoder
  int   errors = 0;
  int   items = 0;
  int   burst_left = 0;

  function automatic int unsigned size_of(logic [3:0] v);
    if (v < 4'd2) return 2;
    if (v > 4'd9) return 9;
    return v;
  endfunction

  function automatic void restart_table();
    m_width = size_of(m_size) + 1;
    m_free  = (1 << size_of(m_size)) + 2;
  endfunction

  function automatic void stack_put(int unsigned v);
    if (m_sp < TBL_DEPTH) begin
      m_stack[m_sp] = v[7:0];
      m_sp++;
    end
  endfunction

  // 0: string stacked, 1: bits missing, 2: stream over
  function automatic int decode_code();
    int unsigned clr, ff, code, inc;
    clr = 1 << size_of(m_size);
    ff  = clr + 2;
    while (1) begin
      if (m_bits < m_width) return m_fin ? 2 : 1;
      code   = m_buf & ((1 << m_width) - 1);
      m_buf  = m_buf >> m_width;
      m_bits = m_bits - m_width;
      if (code == clr) begin
        restart_table();
        m_root = 1'b1;
        continue;
      end
      if (code == clr + 1) begin
        m_fin  = 1'b1;
        m_buf  = 0;
        m_bits = 0;
        m_root = 1'b0;
        return 2;
      end
      if (m_root) begin
        m_root  = 1'b0;
        code    = code & (clr - 1);
        m_prev  = code;
        m_first = code & 8'hFF;
        stack_put(m_first);
        return 0;
      end
      // code past the table end behaves as the next free code
      if (code > m_free) code = m_free;
      inc = code;
      if (code == m_free) begin
        stack_put(m_first);
        code = m_prev;
      end
      while (code >= ff) begin
        stack_put(m_suffix[code & 12'hFFF]);
        code = m_prefix[code & 12'hFFF];
      end
      m_first = code & 8'hFF;
      stack_put(m_first);
      if (m_free < TBL_DEPTH) begin
        m_prefix[m_free] = m_prev & 12'hFFF;
        m_suffix[m_free] = m_first;
        m_free++;
      end
      m_prev = inc & 12'hFFF;
      if (m_width < MAX_CODE_BITS_DEF && m_free >= (1 << m_width)) m_width++;
      return 0;
    end
    return 2;
  endfunction

  function automatic out_t lzw_step(in_t it);
    out_t        r;
    int          st;
    int unsigned b;
    r = '0;
    b = it.in_byte;
    if (it.cmd == CMD_PUSH) begin
      if (!m_fin) begin
        if (m_blk == 0) begin
          if (b == 0) m_fin = 1'b1;
          else m_blk = b;
          r.accepted = 1'b1;
        end else if (m_bits <= 16) begin
          m_buf  = (m_buf | (b << m_bits)) & 24'hFFFFFF;
          m_bits = m_bits + 8;
          m_blk--;
          r.accepted = 1'b1;
        end
      end
    end else begin
      st = 0;
      if (m_sp == 0) st = decode_code();
      if (st == 0 && m_sp > 0) begin
        m_sp--;
        r.pixel       = m_stack[m_sp];
        r.pixel_valid = 1'b1;
      end else if (st == 1) begin
        r.need_byte = 1'b1;
      end else begin
        r.done_res = 1'b1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------
  task automatic flag(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t e;
    if (!rst && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        flag("result transaction with nothing expected");
      end else begin
        e = pixel_q.pop_front();
        if (out_data.pixel !== e.pixel)
          flag($sformatf("pixel got %0d want %0d", out_data.pixel, e.pixel));
        if (out_data.pixel_valid !== e.pixel_valid)
          flag($sformatf("pixel_valid got %b want %b", out_data.pixel_valid, e.pixel_valid));
        if (out_data.accepted !== e.accepted)
          flag($sformatf("accepted got %b want %b", out_data.accepted, e.accepted));
        if (out_data.need_byte !== e.need_byte)
          flag($sformatf("need_byte got %b want %b", out_data.need_byte, e.need_byte));
        if (out_data.done_res !== e.done_res)
          flag($sformatf("done_res got %b want %b", out_data.done_res, e.done_res));
      end
    end
  end

  // Receiver stall pattern: modes of no stall, light and heavy stall
  int stall_pct = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(20, 300);
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 75;
      endcase
    end
    mode_left--;
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // ---------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------
  // One input transaction; the model result is queued, or the typed one
  task automatic drive_item(in_t it, bit typed, out_t want, output out_t r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    r = lzw_step(it);
    items++;
    pixel_q.push_back(typed ? want : r);
  endtask

  task automatic write_size(logic [3:0] v);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_size = v;
    restart_table();
    m_root = 1'b0;
  endtask

  // ---------------------------------------------------------------
  // Directed rows
  // ---------------------------------------------------------------
  typedef struct {
    logic       cmd;
    logic [7:0] b;
    bit         typed;
    out_t       want;
  } row_t;

  localparam out_t R_NEED = '{pixel: 8'd0, pixel_valid: 1'b0, accepted: 1'b0,
                              need_byte: 1'b1, done_res: 1'b0};
  localparam out_t R_TAKEN = '{pixel: 8'd0, pixel_valid: 1'b0, accepted: 1'b1,
                               need_byte: 1'b0, done_res: 1'b0};
  localparam out_t R_NONE = '0;
  localparam out_t R_DONE = '{pixel: 8'd0, pixel_valid: 1'b0, accepted: 1'b0,
                              need_byte: 1'b0, done_res: 1'b1};

  row_t rows [14] = '{
    '{CMD_PULL, 8'h00, 1, R_NEED},    // nothing buffered yet
    '{CMD_PUSH, 8'hFF, 1, R_TAKEN},   // longest sub-block
    '{CMD_PUSH, 8'h00, 1, R_TAKEN},
    '{CMD_PUSH, 8'hFE, 1, R_TAKEN},   // first code is not a clear code
    '{CMD_PUSH, 8'h55, 1, R_TAKEN},
    '{CMD_PUSH, 8'h00, 1, R_NONE},    // 24 bits held: refused
    '{CMD_PULL, 8'h00, 0, R_NONE},
    '{CMD_PULL, 8'h00, 0, R_NONE},
    '{CMD_PUSH, 8'h00, 0, R_NONE},
    '{CMD_PULL, 8'h00, 0, R_NONE},
    '{CMD_PULL, 8'h00, 0, R_NONE},
    '{CMD_PULL, 8'h00, 0, R_NONE},
    '{CMD_PUSH, 8'hA5, 1, R_NONE},    // after the end: refused
    '{CMD_PULL, 8'h00, 1, R_DONE}
  };

  task automatic run_rows(int lo, int hi);
    out_t r;
    in_t  it;
    for (int i = lo; i <= hi; i++) begin
      it.cmd     = rows[i].cmd;
      it.in_byte = rows[i].b;
      drive_item(it, rows[i].typed, rows[i].want, r);
    end
  endtask

  // ---------------------------------------------------------------
  // Code stream generation
  // ---------------------------------------------------------------
  bit          code_bits [$];
  logic [7:0]  byte_q [$];
  int unsigned g_w, g_free;
  bit          g_root;

  task automatic put_code(int unsigned code, int unsigned w);
    logic [7:0] v;
    for (int b = 0; b < w; b++) code_bits.push_back(code[b]);
    while (code_bits.size() >= 8) begin
      for (int b = 0; b < 8; b++) v[b] = code_bits.pop_front();
      byte_q.push_back(v);
    end
  endtask

  function automatic int unsigned pick_code(int unsigned clr, int unsigned ff);
    int r;
    r = $urandom_range(0, 99);
    if (g_root || r < 70) return $urandom_range(0, clr - 1);
    if (r < 85 && g_free > ff) return $urandom_range(ff, g_free - 1);
    if (r < 95 && g_free < (1 << g_w)) return g_free;               // KwKwK
    if (g_free + 1 < (1 << g_w)) return $urandom_range(g_free + 1, (1 << g_w) - 1);
    return $urandom_range(0, clr - 1);
  endfunction

  // Push queued bytes and pull pixels. A middle phase stops once the decoder
  // starves with nothing queued; the last phase ends the stream.
  task automatic feed(bit last);
    bit   need, refused, is_data;
    in_t  it;
    out_t r;
    need = 0;
    refused = 0;
    while (1) begin
      if (last && byte_q.size() == 0 && m_blk == 0 && !m_fin) begin
        it.cmd = CMD_PUSH;             // zero length byte ends the data
        it.in_byte = 8'h00;
        drive_item(it, 0, R_NONE, r);
      end else if (byte_q.size() > 0 && !refused && (need || $urandom_range(0, 2) != 0)) begin
        is_data = (m_blk != 0);
        it.cmd = CMD_PUSH;
        it.in_byte = is_data ? byte_q[0] : 8'($urandom_range(1, byte_q.size() < 255 ?
                                                              byte_q.size() : 255));
        drive_item(it, 0, R_NONE, r);
        if (r.accepted) begin
          if (is_data) void'(byte_q.pop_front());
          need = 0;
        end else begin
          refused = 1;
        end
      end else begin
        it.cmd = CMD_PULL;
        it.in_byte = 8'($urandom());
        drive_item(it, 0, R_NONE, r);
        refused = 0;
        need = r.need_byte;
        if (r.done_res) break;
        if (!last && need && byte_q.size() == 0) break;
      end
    end
  endtask

  task automatic run_phase(logic [3:0] sz, bit full_tab, bit last);
    int unsigned s, clr, ff, lft, n, extra;
    feed(0);                           // decoder starved, stack empty
    write_size(sz);
    s = size_of(sz);
    clr = 1 << s;
    ff = clr + 2;
    g_w = s + 1;
    g_free = ff;
    // leftover zero bits decode as filler codes; pad them out to a code edge
    lft = m_bits;
    while (lft >= g_w) begin
      lft -= g_w;
      g_free++;
      if (g_w < MAX_CODE_BITS_DEF && g_free >= (1 << g_w)) g_w++;
    end
    if (lft > 0) begin
      put_code(0, g_w - lft);
      g_free++;
      if (g_w < MAX_CODE_BITS_DEF && g_free >= (1 << g_w)) g_w++;
    end
    put_code(clr, g_w);
    g_w = s + 1;
    g_free = ff;
    g_root = 1;
    n = full_tab ? 0 : $urandom_range(20, 90);
    extra = 60;
    while (full_tab ? (g_free < TBL_DEPTH || extra > 0) : n > 0) begin
      if (!full_tab) n--;
      else if (g_free >= TBL_DEPTH) extra--;
      if (!full_tab && !g_root && $urandom_range(0, 99) < 3) begin
        put_code(clr, g_w);
        g_w = s + 1;
        g_free = ff;
        g_root = 1;
      end else begin
        put_code(pick_code(clr, ff), g_w);
        if (g_root) begin
          g_root = 0;
        end else begin
          if (g_free < TBL_DEPTH) g_free++;
          if (g_w < MAX_CODE_BITS_DEF && g_free >= (1 << g_w)) g_w++;
        end
      end
    end
    if (last) put_code(clr + 1, g_w);
    while (code_bits.size() % 8 != 0) code_bits.push_back(1'b0);
    put_code(0, 0);
    // an open sub-block from earlier must be filled before the zero length
    if (last) while (byte_q.size() < m_blk) byte_q.push_back(8'h00);
    feed(last);
  endtask

  // ---------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------
  initial begin
    m_size = MIN_SIZE_RST;
    m_sp = 0; m_buf = 0; m_bits = 0; m_prev = 0; m_first = 0; m_blk = 0;
    m_root = 0; m_fin = 0;
    restart_table();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_rows(0, 11);
    run_phase(4'd2, 0, 0);
    run_phase(4'd15, 0, 0);
    run_phase(4'd0, 0, 0);
    run_phase(4'd9, 0, 0);
    run_phase(4'd5, 0, 0);
    while (items < 1550) run_phase(4'($urandom_range(0, 15)), 0, 0);
    run_phase(4'($urandom_range(2, 9)), 0, 1);
    run_rows(12, 13);

    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // Hang guard
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/glz_pkg.sv
hdl/glz_ram.sv
hdl/glz_ctrl.sv
hdl/gif_lzw_decoder.sv
dv/tb.sv
